// ===== src/mvma_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and beat types for the matrix-vector multiply-accumulate block.
package mvma_pkg;

    localparam int MAX_ORDER = 512;
    localparam int ADDR_W    = $clog2(MAX_ORDER);
    localparam int ORDER_W   = ADDR_W + 1;
    localparam int SIZE_W    = 10;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;
    localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sd0;
    localparam logic [SIZE_W-1:0]        SIZE_RESET  = SIZE_W'(MAX_ORDER);

    typedef struct packed {
        logic                     kind;
        logic [ADDR_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] y_old;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_new;
        logic [ADDR_W-1:0]        row;
        logic                     last_row;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
    } cfg_write_t;

endpackage

// ===== src/mvma_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat per handshake.
interface mvma_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/mvma_ram.sv =====
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with registered read data.
module mvma_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/matrix_vector_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// Top level of the Q16.16 square matrix-vector multiply-accumulate block.
//
// Computes y = alpha*A*x + beta*y one row at a time. An x-load beat writes the vector RAM
// at the accepting edge. A matrix beat has a multiply and an accumulate step: the x
// element is read from the vector RAM at the accepting edge, the product is formed in the
// shared 33x33 multiplier, and the wide row sum is updated. The beat on the last column
// of a row then goes on to the finishing steps, in which the shared multiplier forms alpha
// times the upper and lower halves of the row sum and beta times the old y, before the
// result is rounded, saturated and placed in the output register. That last step waits
// while an earlier result still sits unread in the output register; new beats are taken
// while a finished result waits. The vector RAM is not cleared after reset, so every x
// entry must be loaded before a matrix beat uses it.
module matrix_vector_multiply_accumulate (
    input  logic         clk,
    input  logic         rst_n,
    mvma_stream_if.sink   cfg,
    mvma_stream_if.sink   items,
    mvma_stream_if.source results
);
    import mvma_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_F1   = 3'd3;
    localparam logic [2:0] ST_F2   = 3'd4;
    localparam logic [2:0] ST_F3   = 3'd5;
    localparam logic [2:0] ST_F4   = 3'd6;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;

    logic signed [DATA_W-1:0] alpha_reg;
    logic signed [DATA_W-1:0] beta_reg;
    logic [SIZE_W-1:0]        size_reg;

    logic [ADDR_W-1:0]        col_reg;
    logic [ADDR_W-1:0]        row_reg;
    logic signed [SUM_W-1:0]  row_sum_reg;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] yold_reg;
    logic [63:0]              mul_reg;
    logic [63:0]              hi_reg;
    logic [63:0]              lo_reg;

    logic                     out_valid_reg;
    result_t                  out_data_reg;

    logic                     item_acc;
    logic                     load_acc;
    logic                     matrix_acc;
    logic                     out_free;
    logic [DATA_W-1:0]        x_rd;

    logic [ORDER_W-1:0]       order_n;
    logic                     col_last;
    logic                     row_last;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_full;

    logic [SUM_W:0]           acc_wide;
    logic [SUM_W-1:0]         acc_sat;

    logic [49:0]              low_sum;
    logic [33:0]              low;
    logic [65:0]              t_sum;
    logic [DATA_W-1:0]        y_sat;

    assign item_acc   = items.valid && items.ready;
    assign load_acc   = item_acc && (items.data.kind == KIND_LOAD);
    assign matrix_acc = item_acc && (items.data.kind == KIND_MATRIX);
    assign out_free   = !out_valid_reg || results.ready;

    assign items.ready   = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // The x element of the current column is fetched at the edge that takes the beat.
    mvma_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_x_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (items.data.index),
        .wdata (items.data.value),
        .re    (matrix_acc),
        .raddr (col_reg),
        .rdata (x_rd)
    );

    always_comb
    begin
        if (size_reg == '0)
        begin
            order_n = ORDER_W'(1);
        end
        else if (int'(size_reg) > MAX_ORDER)
        begin
            order_n = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_n = ORDER_W'(size_reg);
        end
    end

    assign col_last = (ORDER_W'(col_reg) + ORDER_W'(1)) >= order_n;
    assign row_last = (ORDER_W'(row_reg) + ORDER_W'(1)) >= order_n;

    // One shared multiplier serves the element products and the three finishing products.
    always_comb
    begin
        case (state_reg)
            ST_MUL:
            begin
                mul_a = {value_reg[DATA_W-1], value_reg};
                mul_b = {x_rd[DATA_W-1], x_rd};
            end
            ST_F1:
            begin
                mul_a = {row_sum_reg[SUM_W-1], row_sum_reg[SUM_W-1:16]};
                mul_b = {alpha_reg[DATA_W-1], alpha_reg};
            end
            ST_F2:
            begin
                mul_a = {17'b0, row_sum_reg[15:0]};
                mul_b = {alpha_reg[DATA_W-1], alpha_reg};
            end
            ST_F3:
            begin
                mul_a = {beta_reg[DATA_W-1], beta_reg};
                mul_b = {yold_reg[DATA_W-1], yold_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // The product is floored to Q16.16 by dropping its low 16 bits.
    always_comb
    begin
        acc_wide = {row_sum_reg[SUM_W-1], row_sum_reg} + {mul_reg[63], mul_reg[63:16]};
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
        begin
            acc_sat = acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_wide[SUM_W-1:0];
        end
    end

    // The low halves are summed first so the whole result sees a single floor.
    always_comb
    begin
        low_sum = lo_reg[49:0] + {34'b0, mul_reg[15:0]};
        low     = low_sum[49:16];
        t_sum   = {{2{hi_reg[63]}}, hi_reg}
                + {{18{mul_reg[63]}}, mul_reg[63:16]}
                + {{32{low[33]}}, low};
        if (t_sum[65] && !(&t_sum[64:31]))
        begin
            y_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else if (!t_sum[65] && (|t_sum[64:31]))
        begin
            y_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            y_sat = t_sum[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (matrix_acc) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = col_last ? ST_F1 : ST_IDLE;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_F3;
            ST_F3:   state_next = ST_F4;
            ST_F4:   if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= ALPHA_RESET;
            beta_reg      <= BETA_RESET;
            size_reg      <= SIZE_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            row_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    CFG_ALPHA: alpha_reg <= cfg.data.value;
                    CFG_BETA:  beta_reg  <= cfg.data.value;
                    CFG_SIZE:  size_reg  <= cfg.data.value[SIZE_W-1:0];
                    default:   ;
                endcase
            end

            if (state_reg == ST_ACC)
            begin
                row_sum_reg <= acc_sat;
                if (!col_last)
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                end
            end

            if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_F4) && out_free)
            begin
                out_valid_reg <= 1'b1;
                row_sum_reg   <= '0;
                col_reg       <= '0;
                row_reg       <= row_last ? '0 : row_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (matrix_acc)
        begin
            value_reg <= items.data.value;
            yold_reg  <= items.data.y_old;
        end

        case (state_reg) inside
            ST_MUL, ST_F1:
            begin
                mul_reg <= mul_full[63:0];
            end
            ST_F2:
            begin
                hi_reg  <= mul_reg;
                mul_reg <= mul_full[63:0];
            end
            ST_F3:
            begin
                lo_reg  <= mul_reg;
                mul_reg <= mul_full[63:0];
            end
            default:
            begin
            end
        endcase

        if ((state_reg == ST_F4) && out_free)
        begin
            out_data_reg.y_new    <= y_sat;
            out_data_reg.row      <= row_reg;
            out_data_reg.last_row <= row_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_matrix_starts: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_acc |=> (state_reg == ST_MUL))
        else $error("matrix beat did not start the multiply step");

    a_load_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> ($stable(col_reg) && $stable(row_reg) && $stable(row_sum_reg)))
        else $error("x load disturbed the row counters or row sum");

    a_acc_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |=> ((state_reg == ST_IDLE) || (state_reg == ST_F1)))
        else $error("accumulate step left to an unexpected state");

    a_emit_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_F4) && out_free)
        |=> (out_valid_reg && (col_reg == '0) && (row_sum_reg == '0)))
        else $error("finished row did not post a result and clear the row state");
`endif

endmodule
